// ----- rtl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] CAP_RESET   = 16'hFFFF;
	localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
	localparam logic [20:0] CP_OFFSET   = 21'h10000;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;   // 0xD800 >> 10
	localparam logic [5:0]  LO_SURR_TAG = 6'b110111;   // 0xDC00 >> 10
	localparam logic [4:0]  SURR_BLOCK  = 5'b11011;    // bits 15:11 of D800-DFFF

	// number of UTF-16 units carried by the codepoint of a command
	localparam logic [1:0] CP_NONE   = 2'd0;
	localparam logic [1:0] CP_SINGLE = 2'd1;
	localparam logic [1:0] CP_PAIR   = 2'd2;

	// one classified byte: replacement units first, then an optional codepoint
	typedef struct packed {
		logic [2:0]  n_repl;
		logic [1:0]  cp_units;
		logic [20:0] cp;
		logic        last;
		logic [15:0] length;
	} cmd_t;

endpackage

// ----- rtl/u8u16_front.sv -----
// ----------------------------------------------------------------------------
// u8u16_front
// Decodes UTF-8 bytes, tracks the unit count against the capacity and issues
// one command per byte that produces output or ends a string.
// ----------------------------------------------------------------------------
module u8u16_front
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        push,
	output cmd_t        cmd
);

	logic [15:0] cap_q;
	logic [20:0] pv_q;
	logic [1:0]  exp_q;
	logic [1:0]  pend_q;
	logic [15:0] uw_q;
	logic        stop_q;

	logic [20:0] pv_n;
	logic [1:0]  exp_n;
	logic [1:0]  pend_n;
	logic [2:0]  nrep;
	logic        has_cp;
	logic [20:0] cp;
	logic        is_pair;
	logic [15:0] room;
	logic [15:0] room2;
	logic        stop_rep;
	logic        cp_ok;
	logic        stop_cp;
	logic [2:0]  rep_emit;
	logic [1:0]  cp_k;
	logic [15:0] uw_n;

	always_comb begin
		logic lead;
		lead   = 1'b0;
		pv_n   = pv_q;
		exp_n  = exp_q;
		pend_n = pend_q;
		nrep   = 3'd0;
		has_cp = 1'b0;
		cp     = '0;
		if (!stop_q) begin
			if (exp_q == 2'd0) begin
				lead = 1'b1;
			end else if (in_byte[7:6] == 2'b10) begin
				pv_n   = {pv_q[14:0], in_byte[5:0]};
				pend_n = pend_q + 2'd1;
				if (pend_n >= exp_q) begin
					cp     = pv_n;
					has_cp = 1'b1;
					pv_n   = '0;
					exp_n  = 2'd0;
					pend_n = 2'd0;
				end
			end else begin
				// broken sequence: one replacement for the lead and each continuation
				nrep  = {1'b0, pend_q} + 3'd1;
				pv_n  = '0;
				exp_n = 2'd0;
				lead  = 1'b1;
			end
			if (lead) begin
				pend_n = 2'd0;
				if (!in_byte[7]) begin
					has_cp = 1'b1;
					cp     = {13'd0, in_byte};
				end else if (in_byte[7:5] == 3'b110) begin
					exp_n = 2'd1;
					pv_n  = {16'd0, in_byte[4:0]};
				end else if (in_byte[7:4] == 4'b1110) begin
					exp_n = 2'd2;
					pv_n  = {17'd0, in_byte[3:0]};
				end else if (in_byte[7:3] == 5'b11110) begin
					exp_n = 2'd3;
					pv_n  = {18'd0, in_byte[2:0]};
				end else begin
					nrep = nrep + 3'd1;
				end
			end
			// string ends inside a sequence: flush what is pending
			if (last_byte && exp_n != 2'd0) begin
				nrep = nrep + 3'd1 + {1'b0, pend_n};
			end
		end
	end

	assign is_pair  = (cp[20:16] != 5'd0) || (cp[15:11] == SURR_BLOCK);
	assign cp_k     = is_pair ? CP_PAIR : CP_SINGLE;
	assign room     = (cap_q > uw_q) ? (cap_q - uw_q) : 16'd0;
	assign stop_rep = ({13'd0, nrep} > room);
	assign rep_emit = stop_rep ? room[2:0] : nrep;
	assign room2    = room - {13'd0, rep_emit};
	assign cp_ok    = has_cp && !stop_rep && ({14'd0, cp_k} <= room2);
	assign stop_cp  = has_cp && !stop_rep && !cp_ok;
	assign uw_n     = uw_q + {13'd0, rep_emit} + (cp_ok ? {14'd0, cp_k} : 16'd0);

	assign push = accept && (last_byte || rep_emit != 3'd0 || cp_ok);

	always_comb begin
		cmd.n_repl   = rep_emit;
		cmd.cp_units = cp_ok ? cp_k : CP_NONE;
		cmd.cp       = cp;
		cmd.last     = last_byte;
		cmd.length   = uw_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			exp_q  <= 2'd0;
			pend_q <= 2'd0;
			uw_q   <= '0;
			stop_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pv_q   <= '0;
				exp_q  <= 2'd0;
				pend_q <= 2'd0;
				uw_q   <= '0;
				stop_q <= 1'b0;
			end else begin
				pv_q   <= pv_n;
				exp_q  <= exp_n;
				pend_q <= pend_n;
				uw_q   <= uw_n;
				stop_q <= stop_q | stop_rep | stop_cp;
			end
		end
	end

endmodule

// ----- rtl/u8u16_queue.sv -----
// ----------------------------------------------------------------------------
// u8u16_queue
// Small command queue between the decoder and the unit emitter.
// ----------------------------------------------------------------------------
module u8u16_queue
	import u8u16_pkg::*;
#(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/u8u16_back.sv -----
// ----------------------------------------------------------------------------
// u8u16_back
// Expands queued commands into UTF-16 result items, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module u8u16_back
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_unit,
	output logic        out_unit_valid,
	output logic        out_end,
	output logic [15:0] out_length
);

	cmd_t        cur_q;
	logic        cur_valid_q;
	logic        cur_pair_q;
	logic        out_valid_q;
	logic [15:0] out_unit_q;
	logic        out_uv_q;
	logic        out_end_q;
	logic [15:0] out_len_q;

	logic        adv;
	logic        final_item;
	logic [3:0]  remaining;
	logic [20:0] d;
	logic [15:0] unit_n;
	logic        uv_n;

	assign adv        = cur_valid_q && (!out_valid_q || out_ready);
	assign remaining  = {1'b0, cur_q.n_repl} + {2'b00, cur_q.cp_units};
	assign final_item = (remaining <= 4'd1);
	assign pop        = !empty && (!cur_valid_q || (adv && final_item));
	assign d          = cur_q.cp - CP_OFFSET;
	assign uv_n       = (remaining != 4'd0);

	always_comb begin
		unit_n = 16'd0;
		if (cur_q.n_repl != 3'd0) begin
			unit_n = REPL_UNIT;
		end else if (cur_q.cp_units == CP_PAIR) begin
			unit_n = {HI_SURR_TAG, d[19:10]};
		end else if (cur_q.cp_units == CP_SINGLE) begin
			unit_n = cur_pair_q ? {LO_SURR_TAG, d[9:0]} : cur_q.cp[15:0];
		end
	end

	// load the next command, or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
		end else if (adv && final_item) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= head;
			cur_pair_q <= (head.cp_units == CP_PAIR);
		end else if (adv) begin
			if (cur_q.n_repl != 3'd0) begin
				cur_q.n_repl <= cur_q.n_repl - 3'd1;
			end else if (cur_q.cp_units != CP_NONE) begin
				cur_q.cp_units <= cur_q.cp_units - 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_unit_q <= unit_n;
			out_uv_q   <= uv_n;
			out_end_q  <= final_item && cur_q.last;
			out_len_q  <= (final_item && cur_q.last) ? cur_q.length : 16'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_unit       = out_unit_q;
	assign out_unit_valid = out_uv_q;
	assign out_end        = out_end_q;
	assign out_length     = out_len_q;

endmodule

// ----- rtl/utf8_to_utf16_transcoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// UTF-8 byte stream in, UTF-16 unit stream out, with malformed input replaced
// by U+FFFD and a per-string unit capacity.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                       | tuser      | tlast
//  s_axis   | in  | [7:0] in_byte               | -          | last_byte
//  m_axis   | out | [15:0] unit, [31:16] length | unit_valid | end_of_string
//  cfg      | in  | cfg_wdata = out_capacity    | -          | -
//
//  A byte is taken every cycle while the command queue has room. A byte yields
//  0 to 4 result items; the emitter sends one item per cycle while the output is
//  not stalled, and the queue soaks up bursts.
//  A result passes through the queue, the command register and the output register.
//  Reset clears control state only; no clearing pass is needed.
//  Output stalls back up through the queue to s_axis_tready.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
	import u8u16_pkg::*;
#(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] unit, [31:16] length
	output logic        m_axis_tuser,   // [0] unit_valid
	output logic        m_axis_tlast
);

	logic        accept;
	logic        q_push;
	cmd_t        q_in;
	cmd_t        q_head;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	logic [15:0] unit;
	logic [15:0] length;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_byte   (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.push      (q_push),
		.cmd       (q_in)
	);

	u8u16_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	u8u16_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.empty          (q_empty),
		.pop            (q_pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_unit       (unit),
		.out_unit_valid (m_axis_tuser),
		.out_end        (m_axis_tlast),
		.out_length     (length)
	);

	assign m_axis_tdata = {length, unit};

	// an empty item only ever closes a string
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[15:0] == 16'd0)
		else $error("empty result item that does not close a string");

	// length is carried only on the closing item
	a_length_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:16] == 16'd0)
		else $error("length set on an item that does not close a string");

	// the decoder never issues a command into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 strings into the transcoder and checks every UTF-16 result
// against a transcoder model kept in the bench. A directed table covers
// lengths, the malformed cases and the capacity limit. Random phases follow,
// with different capacities; all but phase 1 stall both streams at random.
// ----------------------------------------------------------------------------
module testbench;
	import u8u16_pkg::*;

	typedef struct packed {
		logic [15:0] unit;
		logic        unit_valid;
		logic        end_of_string;
		logic [15:0] length;
	} utf16_result_t;

	typedef struct packed {
		bit            cap_wr;
		logic [15:0]   cap;
		logic [7:0]    in_byte;
		bit            is_last;
		bit            typed;
		utf16_result_t res;
	} stim_row_t;

	localparam int NUM_ROWS       = 24;
	localparam int NUM_PHASES     = 6;
	localparam int BYTES_PER_PHASE = 56;
	localparam int SETTLE_CYCLES  = 16;
	localparam logic [7:0] CONT_TAG = 8'h80;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] in_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [15:0] unit, [31:16] length
	logic        m_axis_tuser;   // [0] unit_valid
	logic        m_axis_tlast;

	utf8_to_utf16_transcoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// transcoder model state
	logic [15:0] capacity;
	logic [20:0] cp_acc;
	int unsigned cont_needed;
	int unsigned cont_seen;
	int unsigned units_out;
	bit          stopped;

	utf16_result_t byte_results[$];
	utf16_result_t units_due[$];
	logic [7:0]    str_bytes[$];

	int  faults;
	int  hold_cycles;
	bit  in_idle;
	bit  out_idle;

	stim_row_t directed [NUM_ROWS] = '{
		'{1'b1, 16'hFFFF, 8'h00, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1, 16'd1}},
		'{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b1, '{16'hFFFD, 1'b1, 1'b1, 16'd1}},
		'{1'b0, 16'h0000, 8'h80, 1'b1, 1'b1, '{16'hFFFD, 1'b1, 1'b1, 16'd1}},
		'{1'b0, 16'h0000, 8'hC2, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'hA9, 1'b1, 1'b0, '0},
		'{1'b0, 16'h0000, 8'hF0, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h9F, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h98, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h80, 1'b1, 1'b0, '0},
		// encoded surrogate decodes into D800 and turns into a wrapped pair
		'{1'b0, 16'h0000, 8'hED, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'hA0, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h80, 1'b1, 1'b0, '0},
		'{1'b0, 16'h0000, 8'hE2, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h41, 1'b1, 1'b0, '0},
		// break with one continuation pending, then a lead cut off by the end
		'{1'b0, 16'h0000, 8'hF4, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h8F, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'hC2, 1'b1, 1'b0, '0},
		'{1'b0, 16'h0000, 8'hF8, 1'b1, 1'b1, '{16'hFFFD, 1'b1, 1'b1, 16'd1}},
		'{1'b1, 16'h0000, 8'h41, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd0}},
		// pair does not fit in one unit: rest of the string is dropped
		'{1'b1, 16'h0001, 8'hF0, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h90, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h80, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h80, 1'b0, 1'b0, '0},
		'{1'b0, 16'h0000, 8'h41, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

	function automatic void add_result(input utf16_result_t r);
		byte_results.insert(byte_results.size(), r);
	endfunction

	function automatic void add_due(input utf16_result_t r);
		units_due.insert(units_due.size(), r);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		str_bytes.insert(str_bytes.size(), b);
	endfunction

	function automatic void clear_sequence();
		cp_acc      = '0;
		cont_needed = 0;
		cont_seen   = 0;
	endfunction

	function automatic void put_codepoint(input logic [20:0] cp);
		logic [20:0] d;
		if (stopped)
			return;
		if (cp <= 21'h00D7FF || (cp >= 21'h00E000 && cp <= 21'h00FFFF)) begin
			if (units_out + 1 > capacity) begin
				stopped = 1'b1;
				return;
			end
			add_result('{cp[15:0], 1'b1, 1'b0, 16'h0000});
			units_out++;
		end else begin
			d = cp - CP_OFFSET;
			if (units_out + 2 > capacity) begin
				stopped = 1'b1;
				return;
			end
			add_result('{{HI_SURR_TAG, d[19:10]}, 1'b1, 1'b0, 16'h0000});
			add_result('{{LO_SURR_TAG, d[9:0]}, 1'b1, 1'b0, 16'h0000});
			units_out += 2;
		end
	endfunction

	function automatic void flush_broken();
		put_codepoint({5'd0, REPL_UNIT});
		for (int k = 0; k < cont_seen; k++)
			put_codepoint({5'd0, REPL_UNIT});
		clear_sequence();
	endfunction

	function automatic void start_lead(input logic [7:0] b);
		if (!b[7]) begin
			put_codepoint({13'd0, b});
		end else if (b[7:5] == 3'b110) begin
			cont_needed = 1;
			cp_acc = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			cont_needed = 2;
			cp_acc = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			cont_needed = 3;
			cp_acc = {18'd0, b[2:0]};
		end else begin
			put_codepoint({5'd0, REPL_UNIT});
		end
		cont_seen = 0;
	endfunction

	// results of one accepted byte land in byte_results
	function automatic void transcode_byte(input logic [7:0] b, input bit is_last);
		logic [20:0] cp;
		byte_results.delete();
		if (!stopped) begin
			if (cont_needed == 0) begin
				start_lead(b);
			end else if (b[7:6] == CONT_TAG[7:6]) begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_seen++;
				if (cont_seen >= cont_needed) begin
					cp = cp_acc;
					clear_sequence();
					put_codepoint(cp);
				end
			end else begin
				flush_broken();
				start_lead(b);
			end
			if (is_last && cont_needed != 0)
				flush_broken();
		end
		if (is_last) begin
			if (byte_results.size() == 0)
				add_result('0);
			byte_results[byte_results.size() - 1].end_of_string = 1'b1;
			byte_results[byte_results.size() - 1].length = units_out[15:0];
			clear_sequence();
			units_out = 0;
			stopped   = 1'b0;
		end
	endfunction

	function automatic void report_fault(input string what, input utf16_result_t want,
			input utf16_result_t got);
		faults++;
		if (faults <= 10)
			$display("%s: want unit %h valid %b eos %b len %0d, got unit %h valid %b eos %b len %0d",
				what, want.unit, want.unit_valid, want.end_of_string, want.length,
				got.unit, got.unit_valid, got.end_of_string, got.length);
	endfunction

	// one character, mostly well formed, sometimes malformed
	function automatic void add_char();
		int kind;
		int n;
		logic [20:0] cp;
		kind = $urandom_range(0, 99);
		cp = 21'($urandom);
		if (kind < 30) begin
			add_byte({1'b0, cp[6:0]});
		end else if (kind < 45) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (kind < 64) begin
			if (kind >= 58)
				cp[15:11] = SURR_BLOCK;
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (kind < 78) begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (kind < 84) begin
			add_byte(cp[7:0]);
		end else if (kind < 90) begin
			add_byte({2'b10, cp[5:0]});
		end else if (kind < 96) begin
			n = $urandom_range(2, 3);
			add_byte(n == 2 ? {4'b1110, cp[3:0]} : {5'b11110, cp[2:0]});
			repeat ($urandom_range(0, n - 1))
				add_byte({2'b10, 6'($urandom)});
		end else begin
			add_byte({5'b11111, cp[2:0]});
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit is_last, input bit typed,
			input utf16_result_t typed_res);
		int gap;
		gap = in_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		transcode_byte(b, is_last);
		if (typed)
			add_due(typed_res);
		else
			foreach (byte_results[k])
				add_due(byte_results[k]);
	endtask

	// a lead byte gives no result, so let the pipe empty after the last one
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (units_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity = value;
	endtask

	task automatic send_random_string(inout int sent);
		str_bytes.delete();
		repeat ($urandom_range(1, 8))
			add_char();
		foreach (str_bytes[k]) begin
			send_byte(str_bytes[k], k == str_bytes.size() - 1, 1'b0, '0);
			sent++;
		end
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				gap = out_idle ? $urandom_range(0, 6) : 0;
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		utf16_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[15:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[31:16]};
			if (units_due.size() == 0)
				report_fault("unexpected transfer", '0, got);
			else if (got !== units_due[0]) begin
				report_fault("mismatch", units_due[0], got);
				void'(units_due.pop_front());
			end else
				void'(units_due.pop_front());
		end
	end

	initial begin
		int sent;
		logic [15:0] cap_value;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		faults        = 0;
		hold_cycles   = 0;
		in_idle       = 1'b1;
		out_idle      = 1'b1;
		capacity      = CAP_RESET;
		clear_sequence();
		units_out = 0;
		stopped   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].cap_wr)
				write_capacity(directed[i].cap);
			send_byte(directed[i].in_byte, directed[i].is_last, directed[i].typed,
				directed[i].res);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       cap_value = CAP_RESET;
				1:       cap_value = 16'd5;
				2:       cap_value = 16'd0;
				3:       cap_value = 16'd2;
				4:       cap_value = 16'($urandom_range(1, 40));
				default: cap_value = CAP_RESET;
			endcase
			write_capacity(cap_value);
			// phase 1 runs both streams flat out
			in_idle  = (p != 1);
			out_idle = (p != 1);
			if (p == NUM_PHASES - 1)
				hold_cycles = 80;
			sent = 0;
			while (sent < BYTES_PER_PHASE)
				send_random_string(sent);
		end

		wait_idle();
		if (faults == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
